/* sv/event_metric_fold_unit_macros.svh */
// Assertion helpers shared by the fold unit
`ifndef EVENT_METRIC_FOLD_UNIT_MACROS_SVH
`define EVENT_METRIC_FOLD_UNIT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define EMF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define EMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/emf_pkg.sv */
package emf_pkg;

    localparam int unsigned METRIC_BITS_DEF   = 48;
    localparam int unsigned FRACTION_BITS_DEF = 16;
    localparam int unsigned COUNT_BITS_DEF    = 16;
    localparam int unsigned STAMP_BITS        = 48;
    localparam int unsigned MODE_BITS         = 3;
    localparam int unsigned APB_DATA_BITS     = 32;
    localparam int unsigned APB_ADDR_BITS     = 3;
    localparam int unsigned MUL_STEPS         = 4;

    localparam logic        REG_MODE = 1'b0;

    localparam logic [MODE_BITS-1:0] MODE_SUM     = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_PRODUCT = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_DIFF    = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_MEAN    = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_MIN     = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_MAX     = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_MUL,
        ST_MUL_FIN,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_FIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic idle;
        logic load;
        logic fold;
        logic mul_step;
        logic mul_fin;
        logic div_init;
        logic div_step;
        logic div_fin;
        logic deliver;
    } ctrl_t;

    typedef struct packed {
        logic mul_path;
        logic mean_run;
        logic last;
    } status_t;

endpackage

/* sv/emf_seq.sv */
module emf_seq #(
    parameter int unsigned METRIC_BITS = emf_pkg::METRIC_BITS_DEF,
    parameter int unsigned COUNT_BITS  = emf_pkg::COUNT_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_valid,
    input  logic                                          out_free,
    input  emf_pkg::status_t                              status,
    output emf_pkg::ctrl_t                                ctrl,
    output logic [$clog2(METRIC_BITS + COUNT_BITS)-1:0]   step
);

    localparam int unsigned SUM_BITS  = METRIC_BITS + COUNT_BITS;
    localparam int unsigned STEP_BITS = $clog2(SUM_BITS);
    localparam logic [STEP_BITS-1:0] MUL_LAST = STEP_BITS'(emf_pkg::MUL_STEPS);
    localparam logic [STEP_BITS-1:0] DIV_LAST = STEP_BITS'(SUM_BITS - 1);

    emf_pkg::state_t       state_reg, state_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= emf_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        ctrl       = '0;
        unique case (state_reg)
            emf_pkg::ST_IDLE: begin
                ctrl.idle = 1'b1;
                if (s_valid) begin
                    ctrl.load  = 1'b1;
                    state_next = emf_pkg::ST_FOLD;
                end
            end
            emf_pkg::ST_FOLD: begin
                ctrl.fold = 1'b1;
                priority if (status.mul_path) begin
                    step_next  = '0;
                    state_next = emf_pkg::ST_MUL;
                end else if (status.last && status.mean_run) begin
                    state_next = emf_pkg::ST_DIV_INIT;
                end else if (status.last) begin
                    state_next = emf_pkg::ST_DONE;
                end else begin
                    state_next = emf_pkg::ST_IDLE;
                end
            end
            emf_pkg::ST_MUL: begin
                ctrl.mul_step = 1'b1;
                if (step_reg == MUL_LAST) begin
                    state_next = emf_pkg::ST_MUL_FIN;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            emf_pkg::ST_MUL_FIN: begin
                ctrl.mul_fin = 1'b1;
                state_next   = status.last ? emf_pkg::ST_DONE : emf_pkg::ST_IDLE;
            end
            emf_pkg::ST_DIV_INIT: begin
                ctrl.div_init = 1'b1;
                step_next     = DIV_LAST;
                state_next    = emf_pkg::ST_DIV;
            end
            emf_pkg::ST_DIV: begin
                ctrl.div_step = 1'b1;
                if (step_reg == '0) begin
                    state_next = emf_pkg::ST_DIV_FIN;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            emf_pkg::ST_DIV_FIN: begin
                ctrl.div_fin = 1'b1;
                state_next   = emf_pkg::ST_DONE;
            end
            emf_pkg::ST_DONE: begin
                if (out_free) begin
                    ctrl.deliver = 1'b1;
                    state_next   = emf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = emf_pkg::ST_IDLE;
            end
        endcase
    end

    assign step = step_reg;

endmodule

/* sv/emf_datapath.sv */
`include "event_metric_fold_unit_macros.svh"

module emf_datapath #(
    parameter int unsigned METRIC_BITS   = emf_pkg::METRIC_BITS_DEF,
    parameter int unsigned FRACTION_BITS = emf_pkg::FRACTION_BITS_DEF,
    parameter int unsigned COUNT_BITS    = emf_pkg::COUNT_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  emf_pkg::ctrl_t                                ctrl,
    input  logic [$clog2(METRIC_BITS + COUNT_BITS)-1:0]   step,
    input  logic [emf_pkg::MODE_BITS-1:0]                 cfg_mode,
    input  logic signed [METRIC_BITS-1:0]                 in_metric,
    input  logic [emf_pkg::STAMP_BITS-1:0]                in_stamp,
    input  logic                                          in_last,
    output emf_pkg::status_t                              status,
    output logic signed [METRIC_BITS-1:0]                 folded_metric,
    output logic [emf_pkg::STAMP_BITS-1:0]                latest_stamp,
    output logic                                          saturated
);

    localparam int unsigned M         = METRIC_BITS;
    localparam int unsigned C         = COUNT_BITS;
    localparam int unsigned SUM_BITS  = M + C;
    localparam int unsigned H         = (M + 1) / 2;
    localparam int unsigned PW        = 4 * H;
    localparam int unsigned STEP_BITS = $clog2(SUM_BITS);

    localparam logic signed [M-1:0] METRIC_MAX = {1'b0, {(M-1){1'b1}}};
    localparam logic signed [M-1:0] METRIC_MIN = {1'b1, {(M-1){1'b0}}};

    // run state
    logic signed [M-1:0]                  acc_reg, acc_next;
    logic [emf_pkg::STAMP_BITS-1:0]       newest_reg, newest_next;
    logic [C-1:0]                         count_reg, count_next;
    logic                                 clip_reg, clip_next;
    logic [emf_pkg::MODE_BITS-1:0]        run_mode_reg, run_mode_next;
    logic signed [SUM_BITS-1:0]           sum_reg, sum_next;

    // item and work registers
    logic signed [M-1:0]                  metric_reg, metric_next;
    logic [emf_pkg::STAMP_BITS-1:0]       stamp_reg, stamp_next;
    logic                                 last_reg, last_next;
    logic [2*H-1:0]                       mag_a_reg, mag_a_next;
    logic [2*H-1:0]                       mag_b_reg, mag_b_next;
    logic                                 neg_reg, neg_next;
    logic [2*H-1:0]                       pp_reg, pp_next;
    logic [PW-1:0]                        prod_reg, prod_next;
    logic [SUM_BITS-1:0]                  dvd_reg, dvd_next;
    logic [C-1:0]                         rem_reg, rem_next;

    logic                                 first;
    logic [emf_pkg::MODE_BITS-1:0]        fold_mode;
    logic signed [M:0]                    add_wide, sub_wide;
    logic [M-1:0]                         mag_acc, mag_in;
    logic [H-1:0]                         a_chunk, b_chunk;
    logic [STEP_BITS-1:0]                 prev_step;
    logic [PW-1:0]                        pp_ext, pp_shifted;
    logic [PW-1:0]                        prod_shifted;
    logic [M-1:0]                         prod_low, prod_limit;
    logic                                 prod_over;
    logic [C:0]                           rem_sh;
    logic                                 rem_ge;
    logic [C:0]                           rem_sub;
    logic                                 noclip_deliver;

    assign first     = (count_reg == '0);
    assign fold_mode = first ? cfg_mode : run_mode_reg;

    assign status.mul_path = !first && (run_mode_reg == emf_pkg::MODE_PRODUCT);
    assign status.mean_run = (fold_mode == emf_pkg::MODE_MEAN);
    assign status.last     = last_reg;

    assign add_wide = {acc_reg[M-1], acc_reg} + {metric_reg[M-1], metric_reg};
    assign sub_wide = {acc_reg[M-1], acc_reg} - {metric_reg[M-1], metric_reg};
    assign mag_acc  = acc_reg[M-1] ? (~acc_reg + M'(1)) : acc_reg;
    assign mag_in   = metric_reg[M-1] ? (~metric_reg + M'(1)) : metric_reg;

    // shared multiplier: one half-width partial product per step
    assign a_chunk   = step[1] ? mag_a_reg[2*H-1:H] : mag_a_reg[H-1:0];
    assign b_chunk   = step[0] ? mag_b_reg[2*H-1:H] : mag_b_reg[H-1:0];
    assign prev_step = step - 1'b1;
    assign pp_ext    = PW'(pp_reg);

    always_comb begin
        unique case (prev_step[1:0])
            2'd0:    pp_shifted = pp_ext;
            2'd3:    pp_shifted = pp_ext << (2 * H);
            default: pp_shifted = pp_ext << H;
        endcase
    end

    assign prod_shifted = prod_reg >> FRACTION_BITS;
    assign prod_low     = prod_shifted[M-1:0];
    assign prod_limit   = {1'b1, {(M-1){1'b0}}} - {{(M-1){1'b0}}, ~neg_reg};
    assign prod_over    = (|prod_shifted[PW-1:M]) || (prod_low > prod_limit);

    // restoring divide, one quotient bit per step
    assign rem_sh  = {rem_reg, dvd_reg[SUM_BITS-1]};
    assign rem_ge  = (rem_sh >= {1'b0, count_reg});
    assign rem_sub = rem_sh - {1'b0, count_reg};

    always_comb begin
        acc_next      = acc_reg;
        newest_next   = newest_reg;
        count_next    = count_reg;
        clip_next     = clip_reg;
        run_mode_next = run_mode_reg;
        sum_next      = sum_reg;
        metric_next   = metric_reg;
        stamp_next    = stamp_reg;
        last_next     = last_reg;
        mag_a_next    = mag_a_reg;
        mag_b_next    = mag_b_reg;
        neg_next      = neg_reg;
        pp_next       = pp_reg;
        prod_next     = prod_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;

        if (ctrl.load) begin
            metric_next = in_metric;
            stamp_next  = in_stamp;
            last_next   = in_last;
        end

        if (ctrl.fold) begin
            if (first) begin
                run_mode_next = cfg_mode;
                acc_next      = metric_reg;
            end else begin
                unique case (run_mode_reg)
                    emf_pkg::MODE_PRODUCT: begin
                        mag_a_next = (2*H)'(mag_acc);
                        mag_b_next = (2*H)'(mag_in);
                        neg_next   = acc_reg[M-1] ^ metric_reg[M-1];
                        prod_next  = '0;
                    end
                    emf_pkg::MODE_DIFF: begin
                        if (sub_wide[M] != sub_wide[M-1]) begin
                            clip_next = 1'b1;
                            acc_next  = sub_wide[M] ? METRIC_MIN : METRIC_MAX;
                        end else begin
                            acc_next = sub_wide[M-1:0];
                        end
                    end
                    emf_pkg::MODE_MEAN: begin
                        acc_next = acc_reg;
                    end
                    emf_pkg::MODE_MIN: begin
                        if (metric_reg < acc_reg) begin
                            acc_next = metric_reg;
                        end
                    end
                    emf_pkg::MODE_MAX: begin
                        if (metric_reg > acc_reg) begin
                            acc_next = metric_reg;
                        end
                    end
                    default: begin
                        if (add_wide[M] != add_wide[M-1]) begin
                            clip_next = 1'b1;
                            acc_next  = add_wide[M] ? METRIC_MIN : METRIC_MAX;
                        end else begin
                            acc_next = add_wide[M-1:0];
                        end
                    end
                endcase
            end
            if (count_reg != '1) begin
                sum_next   = sum_reg + {{C{metric_reg[M-1]}}, metric_reg};
                count_next = count_reg + 1'b1;
            end
            if (stamp_reg > newest_reg) begin
                newest_next = stamp_reg;
            end
        end

        if (ctrl.mul_step) begin
            pp_next = a_chunk * b_chunk;
            if (step != '0) begin
                prod_next = prod_reg + pp_shifted;
            end
        end

        if (ctrl.mul_fin) begin
            if (prod_over) begin
                clip_next = 1'b1;
                acc_next  = neg_reg ? METRIC_MIN : METRIC_MAX;
            end else begin
                acc_next = neg_reg ? (~prod_low + M'(1)) : prod_low;
            end
        end

        if (ctrl.div_init) begin
            neg_next = sum_reg[SUM_BITS-1];
            dvd_next = sum_reg[SUM_BITS-1] ? (~sum_reg + SUM_BITS'(1)) : sum_reg;
            rem_next = '0;
        end

        if (ctrl.div_step) begin
            rem_next = rem_ge ? rem_sub[C-1:0] : rem_sh[C-1:0];
            dvd_next = {dvd_reg[SUM_BITS-2:0], rem_ge};
        end

        if (ctrl.div_fin) begin
            acc_next = neg_reg ? (~dvd_reg[M-1:0] + M'(1)) : dvd_reg[M-1:0];
        end

        if (ctrl.deliver) begin
            acc_next      = '0;
            newest_next   = '0;
            count_next    = '0;
            clip_next     = 1'b0;
            run_mode_next = emf_pkg::MODE_SUM;
            sum_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            newest_reg   <= '0;
            count_reg    <= '0;
            clip_reg     <= 1'b0;
            run_mode_reg <= emf_pkg::MODE_SUM;
            sum_reg      <= '0;
        end else begin
            acc_reg      <= acc_next;
            newest_reg   <= newest_next;
            count_reg    <= count_next;
            clip_reg     <= clip_next;
            run_mode_reg <= run_mode_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        metric_reg <= metric_next;
        stamp_reg  <= stamp_next;
        last_reg   <= last_next;
        mag_a_reg  <= mag_a_next;
        mag_b_reg  <= mag_b_next;
        neg_reg    <= neg_next;
        pp_reg     <= pp_next;
        prod_reg   <= prod_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
    end

    assign folded_metric = acc_reg;
    assign latest_stamp  = newest_reg;
    assign saturated     = clip_reg;

    assign noclip_deliver = ctrl.deliver && (run_mode_reg == emf_pkg::MODE_MEAN
                                             || run_mode_reg == emf_pkg::MODE_MIN
                                             || run_mode_reg == emf_pkg::MODE_MAX);

    `EMF_ASSERT_NEXT(a_count_live, aclk, aresetn, ctrl.fold, count_reg != '0, "count zero")
    `EMF_ASSERT_NOW(a_rem_below, aclk, aresetn, ctrl.div_step, rem_reg < count_reg, "bad remainder")
    `EMF_ASSERT_NOW(a_no_clip, aclk, aresetn, noclip_deliver, !clip_reg, "clip flag set")

endmodule

/* sv/event_metric_fold_unit.sv */
// Channel   Direction  Ports                                          Word
// s_        in         s_valid s_ready s_metric s_stamp s_last        one event
// m_        out        m_valid m_ready m_folded_metric m_latest_stamp one result per run
//                      m_saturated
// apb       in/out     psel penable pwrite paddr pwdata prdata pready mode register
//
// An event is accepted, then folded; the last of a run then loads the result into the output register.
// Product mode adds four half-width partial products, a final add and a saturate step.
// A mean run adds a restoring divide at its last event: an init step, the quotient steps, a final step.
// A finished result waits in the output register while the next event is taken;
// the block stalls only when a second result is ready before the first is taken.
// Reset (aresetn low, synchronous) clears the mode, the run state and m_valid.
`include "event_metric_fold_unit_macros.svh"

module event_metric_fold_unit #(
    parameter int unsigned METRIC_BITS   = emf_pkg::METRIC_BITS_DEF,
    parameter int unsigned FRACTION_BITS = emf_pkg::FRACTION_BITS_DEF,
    parameter int unsigned COUNT_BITS    = emf_pkg::COUNT_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [METRIC_BITS-1:0]           s_metric,
    input  logic [emf_pkg::STAMP_BITS-1:0]          s_stamp,
    input  logic                                    s_last,

    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [METRIC_BITS-1:0]           m_folded_metric,
    output logic [emf_pkg::STAMP_BITS-1:0]          m_latest_stamp,
    output logic                                    m_saturated,

    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [emf_pkg::APB_ADDR_BITS-1:0]       paddr,
    input  logic [emf_pkg::APB_DATA_BITS-1:0]       pwdata,
    output logic [emf_pkg::APB_DATA_BITS-1:0]       prdata,
    output logic                                    pready
);

    localparam int unsigned STEP_BITS = $clog2(METRIC_BITS + COUNT_BITS);

    emf_pkg::ctrl_t                      ctrl;
    emf_pkg::status_t                    status;
    logic [STEP_BITS-1:0]                step;
    logic                                out_free;
    logic                                mode_hit;

    logic [emf_pkg::MODE_BITS-1:0]       mode_reg, mode_next;
    logic                                m_valid_reg, m_valid_next;
    logic signed [METRIC_BITS-1:0]       m_metric_reg, m_metric_next;
    logic [emf_pkg::STAMP_BITS-1:0]      m_stamp_reg, m_stamp_next;
    logic                                m_sat_reg, m_sat_next;

    logic signed [METRIC_BITS-1:0]       dp_metric;
    logic [emf_pkg::STAMP_BITS-1:0]      dp_stamp;
    logic                                dp_sat;

    assign mode_hit = (paddr[emf_pkg::APB_ADDR_BITS-1:2] == emf_pkg::REG_MODE);
    assign out_free = !m_valid_reg || m_ready;

    emf_seq #(
        .METRIC_BITS (METRIC_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .status   (status),
        .ctrl     (ctrl),
        .step     (step)
    );

    emf_datapath #(
        .METRIC_BITS   (METRIC_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .step          (step),
        .cfg_mode      (mode_reg),
        .in_metric     (s_metric),
        .in_stamp      (s_stamp),
        .in_last       (s_last),
        .status        (status),
        .folded_metric (dp_metric),
        .latest_stamp  (dp_stamp),
        .saturated     (dp_sat)
    );

    always_comb begin
        mode_next     = mode_reg;
        m_valid_next  = m_valid_reg;
        m_metric_next = m_metric_reg;
        m_stamp_next  = m_stamp_reg;
        m_sat_next    = m_sat_reg;
        if (psel && penable && pwrite && mode_hit) begin
            mode_next = pwdata[emf_pkg::MODE_BITS-1:0];
        end
        if (ctrl.deliver) begin
            m_valid_next  = 1'b1;
            m_metric_next = dp_metric;
            m_stamp_next  = dp_stamp;
            m_sat_next    = dp_sat;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= emf_pkg::MODE_SUM;
            m_valid_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_metric_reg <= m_metric_next;
        m_stamp_reg  <= m_stamp_next;
        m_sat_reg    <= m_sat_next;
    end

    assign s_ready         = ctrl.idle;
    assign m_valid         = m_valid_reg;
    assign m_folded_metric = m_metric_reg;
    assign m_latest_stamp  = m_stamp_reg;
    assign m_saturated     = m_sat_reg;
    assign pready          = 1'b1;
    assign prdata          = (psel && mode_hit) ? emf_pkg::APB_DATA_BITS'(mode_reg) : '0;

    `EMF_ASSERT_NOW(a_deliver_free, aclk, aresetn, ctrl.deliver, out_free, "output word overrun")
    `EMF_ASSERT_NEXT(a_busy_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "ready after accept")
    `EMF_ASSERT_NEXT(a_deliver_shows, aclk, aresetn, ctrl.deliver, m_valid_reg, "result not shown")

endmodule

/* dv/event_metric_fold_unit_test.sv */
`timescale 1ns / 1ps

module event_metric_fold_unit_test;

    localparam int MB = emf_pkg::METRIC_BITS_DEF;
    localparam int FB = emf_pkg::FRACTION_BITS_DEF;
    localparam int CB = emf_pkg::COUNT_BITS_DEF;
    localparam int SB = emf_pkg::STAMP_BITS;
    localparam int AB = emf_pkg::APB_ADDR_BITS;
    localparam int DB = emf_pkg::APB_DATA_BITS;

    typedef logic signed [MB-1:0] metric_t;
    typedef logic [SB-1:0] stamp_t;
    typedef logic [emf_pkg::MODE_BITS-1:0] mode_t;

    typedef struct {
        metric_t folded;
        stamp_t  stamp;
        logic    clipped;
    } run_result_t;

    localparam metric_t METRIC_TOP = {1'b0, {(MB-1){1'b1}}};
    localparam metric_t METRIC_BOT = {1'b1, {(MB-1){1'b0}}};
    localparam metric_t ONE = metric_t'(64'd1 << FB);
    localparam stamp_t STAMP_TOP = {SB{1'b1}};
    localparam mode_t MODE_SPARE_LO = 3'd6;
    localparam mode_t MODE_SPARE_HI = 3'd7;
    localparam int unsigned COUNT_TOP = (64'd1 << CB) - 1;
    localparam int MODE_ADDR = 4 * int'(emf_pkg::REG_MODE);
    localparam int SETTLE_CYCLES = MB + CB + 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic    s_valid = 1'b0;
    logic    s_ready;
    metric_t s_metric = '0;
    stamp_t  s_stamp = '0;
    logic    s_last = 1'b0;

    logic    m_valid;
    logic    m_ready = 1'b0;
    metric_t m_folded_metric;
    stamp_t  m_latest_stamp;
    logic    m_saturated;

    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [AB-1:0] paddr = '0;
    logic [DB-1:0] pwdata = '0;
    logic [DB-1:0] prdata;
    logic          pready;

    mode_t                  mode_shadow = emf_pkg::MODE_SUM;
    mode_t                  run_kind = emf_pkg::MODE_SUM;
    metric_t                fold_acc = '0;
    stamp_t                 run_latest = '0;
    int unsigned            run_count = 0;
    logic                   run_clip = 1'b0;
    logic signed [79:0]     run_total = '0;
    run_result_t            pending_folds[$];
    run_result_t            head;

    int  mismatch_count = 0;
    int  events_sent = 0;
    int  folds_checked = 0;
    int  quiet_cycles = 0;
    int  hold_request = 0;
    int  sink_pause = 0;
    bit  sender_gaps = 1'b1;
    bit  sink_gaps = 1'b1;

    event_metric_fold_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_metric        (s_metric),
        .s_stamp         (s_stamp),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_folded_metric (m_folded_metric),
        .m_latest_stamp  (m_latest_stamp),
        .m_saturated     (m_saturated),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic metric_t clamp_metric(input logic signed [127:0] v);
        logic signed [127:0] top;
        logic signed [127:0] bot;
        top = METRIC_TOP;
        bot = METRIC_BOT;
        if (v > top) begin
            run_clip = 1'b1;
            return METRIC_TOP;
        end
        if (v < bot) begin
            run_clip = 1'b1;
            return METRIC_BOT;
        end
        return v[MB-1:0];
    endfunction

    function automatic metric_t fixed_product(input metric_t a, input metric_t b);
        logic                neg;
        logic signed [127:0] prod;
        logic signed [127:0] mag;
        logic signed [127:0] limit;
        neg = a[MB-1] ^ b[MB-1];
        prod = a * b;
        mag = (prod < 0) ? -prod : prod;
        mag = mag >> FB;
        limit = METRIC_TOP;
        if (neg) begin
            limit = limit + 1;
        end
        if (mag > limit) begin
            run_clip = 1'b1;
            return neg ? METRIC_BOT : METRIC_TOP;
        end
        if (neg) begin
            mag = -mag;
        end
        return mag[MB-1:0];
    endfunction

    function automatic metric_t run_mean();
        logic signed [79:0] divisor;
        logic signed [79:0] q;
        divisor = run_count;
        q = run_total / divisor;
        return q[MB-1:0];
    endfunction

    function automatic void fold_event(input metric_t m, input stamp_t st, input logic last);
        logic signed [127:0] wide;
        run_result_t         res;
        if (run_count == 0) begin
            run_kind = mode_shadow;
            fold_acc = m;
            run_total = m;
            run_count = 1;
        end else begin
            case (run_kind)
                emf_pkg::MODE_PRODUCT: fold_acc = fixed_product(fold_acc, m);
                emf_pkg::MODE_DIFF: begin
                    wide = fold_acc;
                    wide = wide - m;
                    fold_acc = clamp_metric(wide);
                end
                emf_pkg::MODE_MEAN: ;
                emf_pkg::MODE_MIN: if (m < fold_acc) fold_acc = m;
                emf_pkg::MODE_MAX: if (m > fold_acc) fold_acc = m;
                default: begin
                    wide = fold_acc;
                    wide = wide + m;
                    fold_acc = clamp_metric(wide);
                end
            endcase
            if (run_count < COUNT_TOP) begin
                run_total = run_total + m;
                run_count++;
            end
        end
        if (st > run_latest) begin
            run_latest = st;
        end
        if (last) begin
            res.folded = (run_kind == emf_pkg::MODE_MEAN) ? run_mean() : fold_acc;
            res.stamp = run_latest;
            res.clipped = run_clip;
            pending_folds.push_back(res);
            fold_acc = '0;
            run_latest = '0;
            run_count = 0;
            run_clip = 1'b0;
            run_total = '0;
        end
    endfunction

    task automatic send_event(input metric_t m, input stamp_t st, input logic last);
        int gap;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_metric <= m;
        s_stamp <= st;
        s_last <= last;
        do @(posedge aclk); while (!s_ready);
        fold_event(m, st, last);
        events_sent++;
    endtask

    task automatic wait_quiet();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_folds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [AB-1:0] addr, input logic [DB-1:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [AB-1:0] addr, output logic [DB-1:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_mode_reg();
        logic [DB-1:0] rd;
        apb_read(MODE_ADDR, rd);
        if (rd != DB'(mode_shadow)) begin
            report_mismatch("mode register", rd, mode_shadow);
        end
    endtask

    task automatic set_mode(input mode_t v);
        wait_quiet();
        apb_write(MODE_ADDR, DB'(v));
        mode_shadow = v;
        check_mode_reg();
    endtask

    function automatic metric_t rand_metric();
        logic [63:0] raw;
        metric_t     v;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = METRIC_TOP;
            1: v = METRIC_BOT;
            2: v = '0;
            3, 4: v = $signed(raw[20:0]);
            5: begin
                v = $signed(raw[12:1]);
                v = raw[0] ? v - ONE : v + ONE;
            end
            default: v = raw[MB-1:0];
        endcase
        return v;
    endfunction

    function automatic stamp_t rand_stamp();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return '0;
            1: return STAMP_TOP;
            2, 3: return stamp_t'($urandom_range(0, 1000));
            default: return raw[SB-1:0];
        endcase
    endfunction

    always @(negedge aclk) begin
        if (hold_request != 0) begin
            sink_pause = hold_request;
            hold_request = 0;
        end else if (sink_pause == 0 && sink_gaps && $urandom_range(0, 4) == 0) begin
            sink_pause = $urandom_range(1, 6);
        end
        if (sink_pause > 0) begin
            m_ready <= 1'b0;
            sink_pause--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_folds.size() == 0) begin
                report_mismatch("unexpected result word", m_folded_metric, '0);
            end else begin
                head = pending_folds.pop_front();
                if (m_folded_metric !== head.folded) begin
                    report_mismatch("folded_metric", m_folded_metric, head.folded);
                end
                if (m_latest_stamp !== head.stamp) begin
                    report_mismatch("latest_stamp", m_latest_stamp, head.stamp);
                end
                if (m_saturated !== head.clipped) begin
                    report_mismatch("saturated", m_saturated, head.clipped);
                end
                folds_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_register_access();
        mode_t v;
        check_mode_reg();
        for (int i = 0; i < 8; i++) begin
            v = mode_t'(i);
            set_mode(v);
        end
        set_mode(emf_pkg::MODE_SUM);
    endtask

    task automatic test_directed_folds();
        set_mode(emf_pkg::MODE_SUM);
        send_event(METRIC_TOP, '0, 1'b0);
        send_event(1, STAMP_TOP, 1'b1);
        send_event(METRIC_BOT, 48'h5555_5555_5555, 1'b1);
        send_event(METRIC_BOT, 48'hAAAA_AAAA_AAAA, 1'b0);
        send_event(-1, 1, 1'b1);

        set_mode(emf_pkg::MODE_PRODUCT);
        send_event(METRIC_TOP, 3, 1'b0);
        send_event(METRIC_TOP, 2, 1'b1);
        send_event(METRIC_BOT, 0, 1'b0);
        send_event(-ONE, 0, 1'b1);
        send_event(-(ONE * 7) / 2, 9, 1'b0);
        send_event(ONE * 2, 4, 1'b1);

        set_mode(emf_pkg::MODE_DIFF);
        send_event(0, 0, 1'b0);
        send_event(METRIC_BOT, 0, 1'b1);
        send_event(ONE, 7, 1'b0);
        send_event(ONE, 5, 1'b0);
        send_event(-ONE, 6, 1'b1);

        set_mode(emf_pkg::MODE_MEAN);
        send_event(-7, 0, 1'b0);
        send_event(0, 0, 1'b1);
        send_event(METRIC_BOT, 0, 1'b0);
        send_event(METRIC_BOT, 0, 1'b0);
        send_event(METRIC_TOP, STAMP_TOP, 1'b1);

        set_mode(emf_pkg::MODE_MIN);
        send_event(3, 2, 1'b0);
        send_event(METRIC_BOT, 1, 1'b0);
        send_event(METRIC_TOP, 0, 1'b1);

        set_mode(emf_pkg::MODE_MAX);
        send_event(-3, 0, 1'b0);
        send_event(METRIC_TOP, 0, 1'b0);
        send_event(METRIC_BOT, 8, 1'b1);

        set_mode(MODE_SPARE_LO);
        send_event(METRIC_TOP, 0, 1'b0);
        send_event(METRIC_TOP, 0, 1'b1);
        set_mode(MODE_SPARE_HI);
        send_event(5, 11, 1'b1);
    endtask

    task automatic test_mode_switch_mid_run();
        set_mode(emf_pkg::MODE_SUM);
        send_event(ONE, 3, 1'b0);
        set_mode(emf_pkg::MODE_PRODUCT);
        send_event(ONE * 2, 1, 1'b1);
        send_event(ONE * 3, 0, 1'b0);
        send_event(ONE * 2, 0, 1'b1);
    endtask

    task automatic test_random_runs(input int goal);
        int stop_at;
        int len;
        stop_at = events_sent + goal;
        while (events_sent < stop_at) begin
            if ($urandom_range(0, 5) == 0) begin
                set_mode(mode_t'($urandom_range(0, 7)));
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                send_event(rand_metric(), rand_stamp(), i == len - 1);
                if (i != len - 1 && $urandom_range(0, 40) == 0) begin
                    set_mode(mode_t'($urandom_range(0, 7)));
                end
            end
        end
    endtask

    task automatic test_output_backpressure();
        set_mode(emf_pkg::MODE_MAX);
        sender_gaps = 1'b0;
        @(posedge aclk);
        hold_request = LONG_HOLD;
        for (int i = 0; i < 40; i++) begin
            send_event(rand_metric(), rand_stamp(), 1'b1);
        end
        sender_gaps = 1'b1;
    endtask

    task automatic test_quiet_finish(input int goal);
        sender_gaps = 1'b0;
        sink_gaps = 1'b0;
        set_mode(emf_pkg::MODE_SUM);
        test_random_runs(goal);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_register_access();
        test_directed_folds();
        test_mode_switch_mid_run();
        test_random_runs(330);
        test_output_backpressure();
        test_quiet_finish(80);
        wait_quiet();

        $display("Covered %0d events: all fold modes and spare codes, saturation,",
                 events_sent);
        $display("mid-run mode change and output stall; %0d results checked", folds_checked);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
